// ===== hw/rtl/batched_request_frame_parser_crc16_top_macros.svh =====
// Assertion macros shared by the parser modules.
`ifndef BATCHED_REQUEST_FRAME_PARSER_CRC16_TOP_MACROS_SVH
`define BATCHED_REQUEST_FRAME_PARSER_CRC16_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define BRFP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Implication checked on every rising clock edge, reset included.
`define BRFP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hw/rtl/brfp_pkg.sv =====
// ----------------------------------------------------------------------------
// brfp_pkg
// Types and constants of the request frame parser.
// ----------------------------------------------------------------------------
package brfp_pkg;
    localparam int MAX_REQUESTS_DEF = 64;
    localparam int HEADER_BYTES = 18;
    localparam int TXID_BYTES = 16;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ROLE_COUNT   = 3'd0,
        ROLE_LENGTH  = 3'd1,
        ROLE_OPCODE  = 3'd2,
        ROLE_TYPE    = 3'd3,
        ROLE_TXID    = 3'd4,
        ROLE_PAYLOAD = 3'd5,
        ROLE_IGNORED = 3'd6,
        ROLE_STATUS  = 3'd7
    } role_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_CRC_BAD   = 3'd2,
        ST_NO_COUNT  = 3'd3,
        ST_TABLE_CUT = 3'd4,
        ST_REQ_SHORT = 3'd5,
        ST_REQ_CUT   = 3'd6,
        ST_TOO_MANY  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        PH_COUNT    = 3'd0,
        PH_LENGTH   = 3'd1,
        PH_REQUEST  = 3'd2,
        PH_SHORTCHK = 3'd3,
        PH_DONE     = 3'd4,
        PH_ERRORED  = 3'd5
    } phase_t;

    // Queue entry from the front end to the parser.
    typedef struct packed {
        logic       body_vld;
        logic [7:0] body_byte;
        logic       frame_end;
        logic       short_frame;
        logic       crc_bad;
    } fe_item_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction
endpackage

// ===== hw/rtl/brfp_front.sv =====
// ----------------------------------------------------------------------------
// brfp_front
// Holds the two trailer bytes back, runs the CRC and releases body bytes.
// ----------------------------------------------------------------------------
module brfp_front import brfp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_vld,
    output logic       in_rdy,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       q_vld,
    input  logic       q_rdy,
    output fe_item_t   q_item
);
    logic [7:0]  held0_reg, held1_reg;
    logic [1:0]  cnt_reg;
    logic [15:0] crc_reg, crc_next;
    logic        fire;

    assign in_rdy = q_rdy;
    assign q_vld  = in_vld;
    assign fire   = in_vld && q_rdy;
    assign crc_next = (cnt_reg == 2'd2) ? crc16_byte(crc_reg, held0_reg) : crc_reg;

    always_comb begin
        q_item.body_vld    = (cnt_reg == 2'd2);
        q_item.body_byte   = held0_reg;
        q_item.frame_end   = in_end;
        q_item.short_frame = (cnt_reg == 2'd0);
        if (cnt_reg == 2'd2) begin
            q_item.crc_bad = ({in_byte, held1_reg} != crc_next);
        end else begin
            q_item.crc_bad = ({in_byte, held0_reg} != crc_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            crc_reg <= 16'hFFFF;
        end else if (fire) begin
            if (in_end) begin
                cnt_reg <= 2'd0;
                crc_reg <= 16'hFFFF;
            end else begin
                crc_reg <= crc_next;
                if (cnt_reg != 2'd2) cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            if (cnt_reg == 2'd2) begin
                held0_reg <= held1_reg;
                held1_reg <= in_byte;
            end else if (cnt_reg == 2'd1) begin
                held1_reg <= in_byte;
            end else begin
                held0_reg <= in_byte;
            end
        end
    end
endmodule

// ===== hw/rtl/brfp_queue.sv =====
// ----------------------------------------------------------------------------
// brfp_queue
// Short FIFO between the front end and the parser.
// ----------------------------------------------------------------------------
`include "batched_request_frame_parser_crc16_top_macros.svh"
module brfp_queue import brfp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_vld,
    output logic     wr_rdy,
    input  fe_item_t wr_item,
    output logic     rd_vld,
    input  logic     rd_rdy,
    output fe_item_t rd_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    fe_item_t          mem [DEPTH];
    logic [AW-1:0]     wp_reg, rp_reg;
    logic [AW:0]       cnt_reg;
    logic              wr, rd;

    assign wr_rdy  = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_vld  = (cnt_reg != '0);
    assign rd_item = mem[rp_reg];
    assign wr = wr_vld && wr_rdy;
    assign rd = rd_vld && rd_rdy;

    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= wr_item;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    `BRFP_ASSERT(a_no_overflow, aclk, aresetn, cnt_reg <= (AW+1)'(DEPTH), "queue overflow")
    `BRFP_ASSERT(a_cnt_up, aclk, aresetn, (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 1'b1, "count")
    `BRFP_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !rd_vld, "not empty after reset")
endmodule

// ===== hw/rtl/brfp_back.sv =====
// ----------------------------------------------------------------------------
// brfp_back
// Parses body bytes into roles and produces the end-of-frame status.
// ----------------------------------------------------------------------------
`include "batched_request_frame_parser_crc16_top_macros.svh"
module brfp_back import brfp_pkg::*; #(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_vld,
    output logic        q_rdy,
    input  fe_item_t    q_item,
    output logic        m_vld,
    input  logic        m_rdy,
    output logic [7:0]  m_byte,
    output logic [2:0]  m_role,
    output logic [5:0]  m_idx,
    output logic [15:0] m_off,
    output logic [2:0]  m_status,
    output logic        m_last
);
    localparam int TW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int EW = $clog2(MAX_REQUESTS + 1) + 1;

    phase_t        phase_reg, phase_next;
    logic [15:0]   total_reg, total_next;
    logic [EW-1:0] entry_reg, entry_next;
    logic [15:0]   off_reg, off_next;
    logic [7:0]    low_reg, low_next;
    logic [2:0]    err_reg, err_next;
    logic [15:0]   table_mem [MAX_REQUESTS];
    logic [15:0]   len_reg;
    logic [15:0]   nlen_reg;
    logic          tw_en;
    logic [TW-1:0] tw_addr, tr_addr, nr_addr;
    logic [15:0]   tw_data;
    logic          stall_reg, rd_pend;

    // Two output result slots; slot B holds the status following a body byte.
    logic          a_vld_reg, b_vld_reg;
    logic [35:0]   a_reg, b_reg;
    logic          take, out_free;
    logic [35:0]   body_res, stat_res;
    logic [2:0]    st;
    logic [15:0]   off1;
    logic [EW-1:0] nidx;

    assign out_free = !a_vld_reg || (m_rdy && !b_vld_reg);
    assign rd_pend  = (phase_reg == PH_REQUEST || phase_reg == PH_SHORTCHK) && stall_reg;
    assign q_rdy    = out_free && !rd_pend;
    assign take     = q_vld && q_rdy;
    assign off1     = off_reg + 16'd1;

    always_ff @(posedge aclk) begin
        if (tw_en) table_mem[tw_addr] <= tw_data;
        len_reg  <= (tw_en && tw_addr == tr_addr) ? tw_data : table_mem[tr_addr];
        nlen_reg <= table_mem[nr_addr];
    end

    always_comb begin
        phase_next = phase_reg;
        total_next = total_reg;
        entry_next = entry_reg;
        off_next   = off_reg;
        low_next   = low_reg;
        err_next   = err_reg;
        tw_en      = 1'b0;
        tw_addr    = entry_reg[TW-1:0];
        tw_data    = {q_item.body_byte, low_reg};
        tr_addr    = entry_reg[TW-1:0];
        nidx       = entry_reg + 1'b1;
        nr_addr    = (phase_reg == PH_LENGTH) ? '0 : nidx[TW-1:0];
        body_res   = {q_item.body_byte, ROLE_IGNORED, 6'd0, 16'd0, 3'd0};
        if (take && q_item.body_vld) begin
            unique case (phase_reg)
                PH_COUNT: begin
                    body_res = {q_item.body_byte, ROLE_COUNT, 6'd0, off_reg, 3'd0};
                    if (off_reg == 16'd0) begin
                        low_next = q_item.body_byte;
                        off_next = 16'd1;
                    end else begin
                        total_next = {q_item.body_byte, low_reg};
                        off_next   = 16'd0;
                        entry_next = '0;
                        if ({q_item.body_byte, low_reg} > 16'(MAX_REQUESTS)) begin
                            err_next = ST_TOO_MANY;
                            phase_next = PH_ERRORED;
                        end else if ({q_item.body_byte, low_reg} == 16'd0) begin
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_LENGTH;
                        end
                    end
                end
                PH_LENGTH: begin
                    body_res = {q_item.body_byte, ROLE_LENGTH, 6'(entry_reg), off_reg, 3'd0};
                    if (off_reg == 16'd0) begin
                        low_next = q_item.body_byte;
                        off_next = 16'd1;
                    end else begin
                        tw_en = 1'b1;
                        off_next = 16'd0;
                        if (16'(nidx) >= total_reg) begin
                            entry_next = '0;
                            tr_addr = '0;
                            phase_next = PH_REQUEST;
                        end else begin
                            entry_next = nidx;
                        end
                    end
                end
                PH_REQUEST: begin
                    if (off_reg == 16'd0) begin
                        body_res = {q_item.body_byte, ROLE_OPCODE, 6'(entry_reg), 16'd0, 3'd0};
                    end else if (off_reg == 16'd1) begin
                        body_res = {q_item.body_byte, ROLE_TYPE, 6'(entry_reg), 16'd0, 3'd0};
                    end else if (off_reg < 16'(2 + TXID_BYTES)) begin
                        body_res = {q_item.body_byte, ROLE_TXID, 6'(entry_reg),
                                    off_reg - 16'd2, 3'd0};
                    end else begin
                        body_res = {q_item.body_byte, ROLE_PAYLOAD, 6'(entry_reg),
                                    off_reg - 16'(HEADER_BYTES), 3'd0};
                    end
                    off_next = off1;
                    if (off1 >= len_reg) begin
                        off_next = 16'd0;
                        entry_next = nidx;
                        tr_addr = nidx[TW-1:0];
                    end
                end
                PH_SHORTCHK: begin
                    off_next = off1;
                    if (off1 >= len_reg) begin
                        err_next = ST_REQ_SHORT;
                        phase_next = PH_ERRORED;
                    end
                end
                default: ;
            endcase
        end
    end

    // Request entry is classified in the cycle after its length is read.
    logic classify;
    assign classify = stall_reg;

    always_comb begin
        if (q_item.short_frame)       st = ST_SHORT;
        else if (q_item.crc_bad)      st = ST_CRC_BAD;
        else if (err_next != 3'd0)    st = err_next;
        else begin
            unique case (phase_next)
                PH_COUNT:    st = ST_NO_COUNT;
                PH_LENGTH:   st = ST_TABLE_CUT;
                PH_REQUEST:  st = (entry_next == '0 && phase_reg == PH_LENGTH) ||
                                  (entry_next != entry_reg) ?
                                  ((16'(entry_next) >= total_reg ||
                                    entry_next >= EW'(MAX_REQUESTS)) ? ST_OK : ST_REQ_CUT)
                                  : ST_REQ_CUT;
                PH_SHORTCHK: st = ST_REQ_CUT;
                default:     st = ST_OK;
            endcase
        end
        stat_res = {8'd0, ROLE_STATUS, 6'd0, 16'd0, st};
    end

    logic enter_req;
    assign enter_req = take && q_item.body_vld && (phase_next == PH_REQUEST) &&
                       ((phase_reg == PH_LENGTH) || (entry_next != entry_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_COUNT;
            total_reg <= '0;
            entry_reg <= '0;
            off_reg   <= '0;
            low_reg   <= '0;
            err_reg   <= '0;
            stall_reg <= 1'b0;
        end else if (take && q_item.frame_end) begin
            phase_reg <= PH_COUNT;
            total_reg <= '0;
            entry_reg <= '0;
            off_reg   <= '0;
            low_reg   <= '0;
            err_reg   <= '0;
            stall_reg <= 1'b0;
        end else if (classify) begin
            stall_reg <= 1'b0;
            if (16'(entry_reg) >= total_reg || entry_reg >= EW'(MAX_REQUESTS)) begin
                phase_reg <= PH_DONE;
            end else if (len_reg >= 16'(HEADER_BYTES)) begin
                phase_reg <= PH_REQUEST;
            end else if (len_reg == 16'd0) begin
                err_reg <= ST_REQ_SHORT;
                phase_reg <= PH_ERRORED;
            end else begin
                phase_reg <= PH_SHORTCHK;
            end
        end else if (take) begin
            phase_reg <= phase_next;
            total_reg <= total_next;
            entry_reg <= entry_next;
            off_reg   <= off_next;
            low_reg   <= low_next;
            err_reg   <= err_next;
            stall_reg <= enter_req;
        end
    end

    // The status of a frame whose request entry is still unclassified is settled
    // from the same rule: a new request with bytes left to come counts as cut,
    // except a zero length, which the rule above reports as short.
    logic [15:0] new_len;
    logic [2:0]  st_fix;
    assign new_len = (phase_reg == PH_LENGTH && tw_addr == '0) ? tw_data : nlen_reg;

    always_comb begin
        st_fix = st;
        if (!q_item.short_frame && !q_item.crc_bad && err_next == 3'd0 && enter_req &&
            16'(entry_next) < total_reg && entry_next < EW'(MAX_REQUESTS) &&
            new_len == 16'd0) begin
            st_fix = ST_REQ_SHORT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else if (take && (q_item.body_vld || q_item.frame_end)) begin
            a_vld_reg <= 1'b1;
            if (q_item.body_vld) begin
                a_reg     <= body_res;
                b_vld_reg <= q_item.frame_end;
                b_reg     <= {stat_res[35:3], st_fix};
            end else begin
                a_reg <= {stat_res[35:3], st_fix};
            end
        end else if (b_vld_reg && m_rdy) begin
            a_reg     <= b_reg;
            b_vld_reg <= 1'b0;
        end else if (a_vld_reg && m_rdy) begin
            a_vld_reg <= 1'b0;
        end
    end

    assign m_vld    = a_vld_reg;
    assign m_byte   = a_reg[35:28];
    assign m_role   = a_reg[27:25];
    assign m_idx    = a_reg[24:19];
    assign m_off    = a_reg[18:3];
    assign m_status = a_reg[2:0];
    assign m_last   = (a_reg[27:25] == ROLE_STATUS);

    `BRFP_ASSERT(a_b_needs_a, aclk, aresetn, b_vld_reg |-> a_vld_reg, "slot B without A")
    `BRFP_ASSERT(a_hold, aclk, aresetn, (m_vld && !m_rdy) |=> m_vld, "result dropped")
    `BRFP_ASSERT(a_stall_one, aclk, aresetn, stall_reg |=> !stall_reg, "stall too long")
endmodule

// ===== hw/rtl/batched_request_frame_parser_crc16_top.sv =====
// ----------------------------------------------------------------------------
// batched_request_frame_parser_crc16_top
// Length-prefixed request frame parser with CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// Frame bytes enter on the s_axis channel, with tlast on the final byte.
// Every body byte leaves on the m_axis channel tagged with its role, request
// index and field offset; after the final byte one status result follows
// with tlast set. The last two frame bytes are the CRC trailer and are held
// back, so a body byte is released two input bytes after it entered and then
// passes through the queue and the output registers.
// One byte is taken per cycle while the receiver keeps up and the parser does
// not pause. Before the first byte of each request the parser pauses to read
// that request's length from the table memory. A body byte and a frame end in
// the same queue item give two results, the byte first and then the status.
// Reset empties the queue and output registers and starts a new frame; the
// length table needs no clearing. When the receiver stalls, results stay in
// the output registers, the queue fills and s_axis_tready falls.
// ----------------------------------------------------------------------------
module batched_request_frame_parser_crc16_top import brfp_pkg::*; #(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_byte, request_index, field_offset, zero fill
    output logic [5:0]  m_axis_tuser,   // role, status
    output logic        m_axis_tlast    // run_last
);
    logic     fq_vld, fq_rdy, qb_vld, qb_rdy;
    fe_item_t fq_item, qb_item;
    logic [7:0]  o_byte;
    logic [2:0]  o_role, o_status;
    logic [5:0]  o_idx;
    logic [15:0] o_off;

    brfp_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_vld(s_axis_tvalid), .in_rdy(s_axis_tready),
        .in_byte(s_axis_tdata), .in_end(s_axis_tlast),
        .q_vld(fq_vld), .q_rdy(fq_rdy), .q_item(fq_item)
    );

    brfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_vld(fq_vld), .wr_rdy(fq_rdy), .wr_item(fq_item),
        .rd_vld(qb_vld), .rd_rdy(qb_rdy), .rd_item(qb_item)
    );

    brfp_back #(.MAX_REQUESTS(MAX_REQUESTS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_vld(qb_vld), .q_rdy(qb_rdy), .q_item(qb_item),
        .m_vld(m_axis_tvalid), .m_rdy(m_axis_tready),
        .m_byte(o_byte), .m_role(o_role), .m_idx(o_idx), .m_off(o_off),
        .m_status(o_status), .m_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, o_off, o_idx, o_byte};
    assign m_axis_tuser = {o_status, o_role};
endmodule

// ===== tb/sv/batched_request_frame_parser_crc16_top_tb.sv =====
// ----------------------------------------------------------------------------
// batched_request_frame_parser_crc16_top_tb
// Self-checking bench for the request frame parser.
// ----------------------------------------------------------------------------
// Frames are built as byte lists and sent one byte per request with random
// gaps. A predictor in the bench classifies every body byte and works out the
// end-of-frame status. Results are checked field by field, in order, while
// the receiver stalls at random. Most frames are well formed with random
// content; the rest carry bad trailers, cut tables, short or cut requests,
// zero or excessive counts, and trailing bytes.
// ----------------------------------------------------------------------------
module batched_request_frame_parser_crc16_top_tb;
    import brfp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  data;
        logic [2:0]  role;
        logic [5:0]  idx;
        logic [15:0] off;
        logic [2:0]  st;
        logic        last;
    } parse_result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } frame_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;
    logic        m_axis_tlast;

    batched_request_frame_parser_crc16_top dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    logic [7:0]  held [2];
    int          held_n;
    logic [15:0] crc_acc;
    phase_t      phase;
    int          req_total;
    int          entry;
    int          pos;
    logic [7:0]  low_hold;
    logic [15:0] len_tab [MAX_REQUESTS_DEF];
    logic [2:0]  first_err;

    parse_result_t expected_results[$];
    frame_byte_t   pending_bytes[$];
    int errors = 0;
    int results_seen = 0;
    int frames_sent = 0;
    int bytes_queued = 0;
    int status_seen [8];
    longint cycles = 0;
    bit hold_off = 1'b0;

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
        return r;
    endfunction

    task automatic clear_frame();
        held[0] = 0; held[1] = 0; held_n = 0; crc_acc = 16'hFFFF; phase = PH_COUNT;
        req_total = 0; entry = 0; pos = 0; low_hold = 0; first_err = ST_OK;
    endtask

    function automatic parse_result_t mk(logic [7:0] b, role_t r, int i, int o);
        parse_result_t x;
        x.data = b; x.role = r; x.idx = i[5:0]; x.off = o[15:0]; x.st = ST_OK; x.last = 0;
        return x;
    endfunction

    task automatic add_expected(parse_result_t x);
        expected_results.insert(expected_results.size(), x);
    endtask

    task automatic open_request(int i);
        entry = i; pos = 0;
        if (i >= req_total || i >= MAX_REQUESTS_DEF) begin
            phase = PH_DONE;
        end else if (len_tab[i] >= HEADER_BYTES) begin
            phase = PH_REQUEST;
        end else if (len_tab[i] == 0) begin
            first_err = ST_REQ_SHORT; phase = PH_ERRORED;
        end else begin
            phase = PH_SHORTCHK;
        end
    endtask

    task automatic classify_body(logic [7:0] b);
        int o;
        int i;
        o = pos; i = entry;
        crc_acc = crc_step(crc_acc, b);
        case (phase)
            PH_COUNT: begin
                add_expected(mk(b, ROLE_COUNT, 0, o));
                if (o == 0) begin
                    low_hold = b; pos = 1;
                end else begin
                    req_total = {b, low_hold}; pos = 0; entry = 0;
                    if (req_total > MAX_REQUESTS_DEF) begin
                        first_err = ST_TOO_MANY; phase = PH_ERRORED;
                    end else if (req_total == 0) phase = PH_DONE;
                    else phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                add_expected(mk(b, ROLE_LENGTH, i, o));
                if (o == 0) begin
                    low_hold = b; pos = 1;
                end else begin
                    len_tab[i] = {b, low_hold}; pos = 0; entry = i + 1;
                    if (entry >= req_total) open_request(0);
                end
            end
            PH_REQUEST: begin
                if (o == 0) add_expected(mk(b, ROLE_OPCODE, i, 0));
                else if (o == 1) add_expected(mk(b, ROLE_TYPE, i, 0));
                else if (o < HEADER_BYTES) add_expected(mk(b, ROLE_TXID, i, o - 2));
                else add_expected(mk(b, ROLE_PAYLOAD, i, o - HEADER_BYTES));
                pos = o + 1;
                if (pos >= len_tab[i]) open_request(i + 1);
            end
            PH_SHORTCHK: begin
                add_expected(mk(b, ROLE_IGNORED, 0, 0));
                pos = o + 1;
                if (pos >= len_tab[i]) begin
                    first_err = ST_REQ_SHORT; phase = PH_ERRORED;
                end
            end
            default: add_expected(mk(b, ROLE_IGNORED, 0, 0));
        endcase
    endtask

    task automatic predict_byte(frame_byte_t fb);
        parse_result_t s;
        if (held_n >= 2) begin
            classify_body(held[0]);
            held[0] = held[1]; held[1] = fb.data;
        end else begin
            held[held_n] = fb.data; held_n++;
        end
        if (fb.eof) begin
            s = mk(8'h00, ROLE_STATUS, 0, 0);
            s.last = 1'b1;
            if (held_n < 2) s.st = ST_SHORT;
            else if ({held[1], held[0]} != crc_acc) s.st = ST_CRC_BAD;
            else if (first_err != ST_OK) s.st = first_err;
            else case (phase)
                PH_COUNT: s.st = ST_NO_COUNT;
                PH_LENGTH: s.st = ST_TABLE_CUT;
                PH_REQUEST, PH_SHORTCHK: s.st = ST_REQ_CUT;
                default: s.st = ST_OK;
            endcase
            add_expected(s);
            clear_frame();
        end
    endtask

    // Frame construction.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(18, 26);
        if (r < 85) return $urandom_range(0, 17);
        if (r < 97) return $urandom_range(27, 60);
        return $urandom_range(200, 300);
    endfunction

    // kind: 0 good, 1 bad crc, 2 truncate body, 3 extra trailing bytes
    task automatic send_frame(int count, int lens[$], int kind, int cut, bit full_bits);
        logic [7:0] body[$];
        logic [15:0] c;
        body.insert(body.size(), count[7:0]);
        body.insert(body.size(), count[15:8]);
        foreach (lens[i]) begin
            body.insert(body.size(), lens[i][7:0]);
            body.insert(body.size(), lens[i][15:8]);
        end
        foreach (lens[i])
            for (int k = 0; k < lens[i]; k++)
                body.insert(body.size(), full_bits ? 8'hFF : 8'($urandom));
        if (kind == 3) repeat ($urandom_range(1, 5)) body.insert(body.size(), 8'($urandom));
        if (kind == 2 && body.size() > 0) body = body[0:cut % body.size()];
        c = 16'hFFFF;
        foreach (body[i]) c = crc_step(c, body[i]);
        if (kind == 1) c ^= 16'(1 << $urandom_range(0, 15));
        body.insert(body.size(), c[7:0]);
        body.insert(body.size(), c[15:8]);
        foreach (body[i])
            pending_bytes.insert(pending_bytes.size(), '{body[i], i == body.size() - 1});
        bytes_queued += body.size();
        frames_sent++;
    endtask

    task automatic send_raw(int n);
        for (int i = 0; i < n; i++)
            pending_bytes.insert(pending_bytes.size(), '{8'($urandom), i == n - 1});
        bytes_queued += n;
        frames_sent++;
    endtask

    function automatic int gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Input acceptance is sampled at the rising edge.
    bit s_took = 1'b0;
    always @(posedge aclk) begin
        s_took = aresetn && s_axis_tvalid && s_axis_tready;
    end

    // Driver.
    int s_gap = 0;
    int m_gap = 0;
    int burst = 0;
    always @(negedge aclk) begin
        bit rdy;
        if (aresetn) begin
            if (s_took) begin
                predict_byte('{s_axis_tdata, s_axis_tlast});
                void'(pending_bytes.pop_front());
                s_gap = (burst > 0) ? 0 : gap();
            end
            if (burst > 0) burst--;
            else if ($urandom_range(0, 199) == 0) burst = 200;
            if (s_gap > 0) s_gap--;
            if (pending_bytes.size() > 0 && s_gap == 0 && !hold_off) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_bytes[0].data;
                s_axis_tlast <= pending_bytes[0].eof;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            rdy = (burst > 0) || ($urandom_range(0, 99) < 70);
            if (m_gap > 0) begin
                m_gap--;
                rdy = 1'b0;
            end else if (burst == 0 && $urandom_range(0, 299) == 0) begin
                m_gap = $urandom_range(8, 40);
                rdy = 1'b0;
            end
            m_axis_tready <= rdy;
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        parse_result_t got;
        parse_result_t exp;
        cycles++;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.data = m_axis_tdata[7:0];
            got.idx = m_axis_tdata[13:8];
            got.off = m_axis_tdata[29:14];
            got.role = m_axis_tuser[2:0];
            got.st = m_axis_tuser[5:3];
            got.last = m_axis_tlast;
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                exp = expected_results.pop_front();
                if (got.last) status_seen[got.st]++;
                if (got != exp)
                    $display("%0t: mismatch expected %p actual %p", $time, exp, got);
                if (got != exp) errors++;
            end
        end
    end

    initial begin
        int lens[$];
        clear_frame();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed frames.
        lens = '{18, 20}; send_frame(2, lens, 0, 0, 0);
        lens = '{19}; send_frame(1, lens, 0, 0, 1);
        lens = {}; send_frame(0, lens, 0, 0, 0);
        lens = {}; send_frame(0, lens, 3, 0, 0);
        send_raw(1);
        send_raw(2);
        send_raw(3);
        lens = '{18}; send_frame(1, lens, 1, 0, 0);
        lens = {}; send_frame(65, lens, 3, 0, 0);
        lens = {}; send_frame(16'hFFFF, lens, 0, 0, 1);
        lens = '{20, 22}; send_frame(2, lens, 2, 3, 0);
        lens = '{5}; send_frame(1, lens, 0, 0, 0);
        lens = '{0, 18}; send_frame(2, lens, 0, 0, 0);
        lens = '{10}; send_frame(1, lens, 2, 8, 0);
        lens = '{30}; send_frame(1, lens, 2, 20, 0);
        lens = '{18, 19}; send_frame(2, lens, 3, 0, 0);
        lens = {}; for (int i = 0; i < 64; i++) lens.insert(lens.size(), 18);
        send_frame(64, lens, 2, 200, 0);

        // Wait out the directed part once with the sender held off.
        wait (pending_bytes.size() == 0);
        hold_off = 1'b1;
        wait (expected_results.size() == 0);
        hold_off = 1'b0;

        while (bytes_queued < 700) begin
            int k;
            int kind;
            lens = {};
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 3);
            for (int i = 0; i < k; i++) lens.insert(lens.size(), pick_len());
            kind = $urandom_range(0, 99);
            kind = kind < 70 ? 0 : kind < 78 ? 1 : kind < 92 ? 2 : 3;
            if ($urandom_range(0, 19) == 0) send_raw($urandom_range(1, 12));
            else send_frame(k, lens, kind, $urandom_range(0, 65535), 0);
            wait (pending_bytes.size() < 40);
        end

        wait (pending_bytes.size() == 0 && expected_results.size() == 0);
        repeat (50) @(posedge aclk);
        $display("Sent %0d frames; %0d results checked.", frames_sent, results_seen);
        $display("Status counts ok..too many: %p", status_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        wait (cycles > 400000);
        $display("Timeout with %0d results still expected.", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/brfp_pkg.sv
hw/rtl/brfp_front.sv
hw/rtl/brfp_queue.sv
hw/rtl/brfp_back.sv
hw/rtl/batched_request_frame_parser_crc16_top.sv
tb/sv/batched_request_frame_parser_crc16_top_tb.sv
